// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a clock with an active-low asynchronous reset
`define BDLP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// overlapping implication on top of the plain check
`define BDLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	`BDLP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// non-overlapping implication on top of the plain check
`define BDLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	`BDLP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/core/bdlp_pkg.sv =====
// ---------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debounce / long press core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int FIELD_W     = 4;
	localparam int ACC_W       = (NUM_BUTTONS > FIELD_W) ? NUM_BUTTONS : FIELD_W;
	localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

	localparam int DB_W   = 4;
	localparam int CNT_W  = 8;
	localparam int CFG_W  = 8;
	localparam int CIDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_REPEAT     = 2'd2;
	localparam logic [CIDX_W-1:0] REG_LONG_MASK  = 2'd3;

	localparam logic [DB_W-1:0]    RST_DEBOUNCE   = 4'd3;
	localparam logic [CNT_W-1:0]   RST_LONG_PRESS = 8'd60;
	localparam logic [CNT_W-1:0]   RST_REPEAT     = 8'd16;
	localparam logic [FIELD_W-1:0] RST_LONG_MASK  = 4'd5;

	// results owed to the output side at most (one in flight, one waiting)
	localparam logic [1:0] OWED_MAX = 2'd2;

	typedef struct packed {
		logic             sampled;
		logic [DB_W-1:0]  db_cnt;
		logic             stable;
		logic [CNT_W-1:0] hold_cnt;
		logic [CNT_W-1:0] rep_cnt;
	} btn_state_t;

	localparam int STATE_W = $bits(btn_state_t);

	typedef struct packed {
		logic [DB_W-1:0]  debounce;
		logic [CNT_W-1:0] long_press;
		logic [CNT_W-1:0] rep_period;
	} timing_cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] shorts;
		logic [FIELD_W-1:0] longs;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/button_debounce_long_press_repeat_core.sv =====
// ---------------------------------------------------------------------------
// button_debounce_long_press_repeat_core
// debouncer with short press, long press and auto-repeat events per button
// ---------------------------------------------------------------------------
//  channel | handshake                 | payload
//  item    | item_valid / item_stall   | levels (active-low pins)
//  result  | result_valid/result_stall | short_events, long_events
//  config  | cfg_write                 | cfg_index, cfg_data
//
//  in one transaction the sequencer visits one button per cycle through the
//  read and write ports of the state memory
//  the result is queued once the last button leaves the update stage
//  reset clears all button state (valid bits in the memory) and loads the
//  register defaults; no clearing pass is needed
//  up to two results may be owed; a stalled result side holds the item side
//  only once both are outstanding
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press_repeat_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// item channel
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [bdlp_pkg::FIELD_W-1:0]  levels,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [bdlp_pkg::FIELD_W-1:0]       short_events,
	output logic [bdlp_pkg::FIELD_W-1:0]       long_events,
	// configuration port
	input  wire logic                          cfg_write,
	input  wire logic [bdlp_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [bdlp_pkg::CFG_W-1:0]    cfg_data
);

	// configuration registers
	bdlp_pkg::timing_cfg_t              timing_q;
	logic [bdlp_pkg::FIELD_W-1:0]       mask_q;

	// sequencer over the buttons of the current transaction
	logic                               busy_q;
	logic [bdlp_pkg::IDX_W-1:0]         idx_q;
	logic [bdlp_pkg::FIELD_W-1:0]       levels_q;
	logic [1:0]                         owed_q;

	// update stage, lined up with the memory read data
	logic                               v_s1;
	logic [bdlp_pkg::IDX_W-1:0]         addr_s1;
	logic                               pressed_s1;
	logic                               enabled_s1;
	logic                               last_s1;

	logic [bdlp_pkg::ACC_W-1:0]         short_acc_q;
	logic [bdlp_pkg::ACC_W-1:0]         long_acc_q;

	logic                               accept;
	logic                               pop;
	logic                               seq_free;
	logic [bdlp_pkg::ACC_W-1:0]         levels_sh;
	logic [bdlp_pkg::ACC_W-1:0]         mask_sh;
	logic [bdlp_pkg::ACC_W-1:0]         btn_bit;
	logic [bdlp_pkg::ACC_W-1:0]         short_bits;
	logic [bdlp_pkg::ACC_W-1:0]         long_bits;
	bdlp_pkg::btn_state_t               cur_state;
	bdlp_pkg::btn_state_t               nxt_state;
	logic                               short_ev;
	logic                               long_ev;
	logic                               push;
	bdlp_pkg::result_t                  push_data;
	bdlp_pkg::result_t                  head_data;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.debounce     <= bdlp_pkg::RST_DEBOUNCE;
			timing_q.long_press   <= bdlp_pkg::RST_LONG_PRESS;
			timing_q.rep_period   <= bdlp_pkg::RST_REPEAT;
			mask_q                <= bdlp_pkg::RST_LONG_MASK;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bdlp_pkg::REG_DEBOUNCE:   timing_q.debounce <= cfg_data[bdlp_pkg::DB_W-1:0];
				bdlp_pkg::REG_LONG_PRESS: timing_q.long_press <= cfg_data;
				bdlp_pkg::REG_REPEAT:     timing_q.rep_period <= cfg_data;
				bdlp_pkg::REG_LONG_MASK:  mask_q <= cfg_data[bdlp_pkg::FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------- handshake
	assign pop      = result_valid && !result_stall;
	// a new item may enter while the last button of the previous one issues
	assign seq_free = !busy_q || (idx_q == bdlp_pkg::LAST_IDX);
	assign item_stall = !(seq_free && ((owed_q != bdlp_pkg::OWED_MAX) || pop));
	assign accept   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + {1'b0, accept} - {1'b0, pop};
			if (accept) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				busy_q <= (idx_q != bdlp_pkg::LAST_IDX);
				idx_q  <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= levels;
		end
	end

	// ----------------------------------------------------------- issue stage
	// pick this button's pin and enable bit; buttons past the field width
	// read a low pin (pressed) and no enable
	assign levels_sh = bdlp_pkg::ACC_W'(levels_q) >> idx_q;
	assign mask_sh   = bdlp_pkg::ACC_W'(mask_q) >> idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= idx_q;
		pressed_s1 <= ~levels_sh[0];
		enabled_s1 <= mask_sh[0];
		last_s1    <= (idx_q == bdlp_pkg::LAST_IDX);
	end

	bdlp_state_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (busy_q),
		.raddr  (idx_q),
		.we     (v_s1),
		.waddr  (addr_s1),
		.wdata  (nxt_state),
		.rdata  (cur_state)
	);

	// ---------------------------------------------------------- update stage
	bdlp_btn_upd u_upd (
		.cur      (cur_state),
		.pressed  (pressed_s1),
		.enabled  (enabled_s1),
		.cfg      (timing_q),
		.nxt      (nxt_state),
		.short_ev (short_ev),
		.long_ev  (long_ev)
	);

	assign btn_bit    = bdlp_pkg::ACC_W'(1) << addr_s1;
	assign short_bits = short_ev ? btn_bit : '0;
	assign long_bits  = long_ev ? btn_bit : '0;

	// event bits gather over the buttons of one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_acc_q <= '0;
			long_acc_q  <= '0;
		end else if (v_s1) begin
			if (last_s1) begin
				short_acc_q <= '0;
				long_acc_q  <= '0;
			end else begin
				short_acc_q <= short_acc_q | short_bits;
				long_acc_q  <= long_acc_q | long_bits;
			end
		end
	end

	assign push             = v_s1 && last_s1;
	assign push_data.shorts = bdlp_pkg::FIELD_W'(short_acc_q | short_bits);
	assign push_data.longs  = bdlp_pkg::FIELD_W'(long_acc_q | long_bits);

	// ---------------------------------------------------------------- output
	bdlp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (result_valid),
		.head_data  (head_data)
	);

	assign short_events = head_data.shorts;
	assign long_events  = head_data.longs;

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_state_ram.sv =====
// ---------------------------------------------------------------------------
// bdlp_state_ram
// per-button state memory, one read and one write port, registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdlp_state_ram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       re,
	input  wire logic [bdlp_pkg::IDX_W-1:0] raddr,
	input  wire logic                       we,
	input  wire logic [bdlp_pkg::IDX_W-1:0] waddr,
	input  wire bdlp_pkg::btn_state_t       wdata,
	output bdlp_pkg::btn_state_t            rdata
);

	bdlp_pkg::btn_state_t                   mem [bdlp_pkg::NUM_BUTTONS];
	logic [bdlp_pkg::NUM_BUTTONS-1:0]       valid_q;
	bdlp_pkg::btn_state_t                   rd_q;
	logic                                   rd_valid_q;
	logic                                   fwd_q;
	bdlp_pkg::btn_state_t                   fwd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
		fwd_data_q <= wdata;
	end

	// valid bits stand in for a cleared memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
				fwd_q      <= we && (waddr == raddr);
			end
		end
	end

	// a read issued while the same entry is written sees the new data
	always_comb begin
		if (fwd_q) begin
			rdata = fwd_data_q;
		end else if (rd_valid_q) begin
			rdata = rd_q;
		end else begin
			rdata = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_btn_upd.sv =====
// ---------------------------------------------------------------------------
// bdlp_btn_upd
// one poll step of one button: debounce, hold and repeat counting, events
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdlp_btn_upd (
	input  wire bdlp_pkg::btn_state_t  cur,
	input  wire logic                  pressed,
	input  wire logic                  enabled,
	input  wire bdlp_pkg::timing_cfg_t cfg,
	output bdlp_pkg::btn_state_t       nxt,
	output logic                       short_ev,
	output logic                       long_ev
);

	always_comb begin
		logic [bdlp_pkg::CNT_W-1:0] held;
		logic                       reached;
		nxt      = cur;
		short_ev = 1'b0;
		long_ev  = 1'b0;
		held     = cur.hold_cnt;
		reached  = 1'b0;

		if (pressed != nxt.sampled) begin
			nxt.sampled = pressed;
			nxt.db_cnt  = '0;
		end else if (nxt.db_cnt < cfg.debounce) begin
			nxt.db_cnt = nxt.db_cnt + 1'b1;
		end

		if ((nxt.db_cnt >= cfg.debounce) && (nxt.stable != nxt.sampled)) begin
			nxt.stable   = nxt.sampled;
			nxt.hold_cnt = '0;
			nxt.rep_cnt  = '0;
			short_ev     = !nxt.stable && (!enabled || (held < cfg.long_press));
		end

		if (nxt.stable && enabled) begin
			if (nxt.hold_cnt != bdlp_pkg::CNT_MAX) begin
				nxt.hold_cnt = nxt.hold_cnt + 1'b1;
				reached      = (nxt.hold_cnt == cfg.long_press);
			end
			if (reached) begin
				long_ev     = 1'b1;
				nxt.rep_cnt = '0;
			end else if (nxt.hold_cnt >= cfg.long_press) begin
				if (nxt.rep_cnt != bdlp_pkg::CNT_MAX) begin
					nxt.rep_cnt = nxt.rep_cnt + 1'b1;
				end
				if (nxt.rep_cnt >= cfg.rep_period) begin
					long_ev     = 1'b1;
					nxt.rep_cnt = '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_outq.sv =====
// ---------------------------------------------------------------------------
// bdlp_outq
// two-entry result queue between the update pipeline and the output channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdlp_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bdlp_pkg::result_t push_data,
	input  wire logic              pop,
	output logic                   head_valid,
	output bdlp_pkg::result_t      head_data
);

	logic [1:0]        count_q;
	bdlp_pkg::result_t head_q;
	bdlp_pkg::result_t tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (count_q)
			2'd0: begin
				if (push) head_q <= push_data;
			end
			2'd1: begin
				if (push && pop) begin
					head_q <= push_data;
				end else if (push) begin
					tail_q <= push_data;
				end
			end
			default: begin
				if (pop) head_q <= tail_q;
			end
		endcase
	end

	assign head_valid = (count_q != 2'd0);
	assign head_data  = head_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdlp_checker.sv =====
// ---------------------------------------------------------------------------
// bdlp_checker
// port-level checks of the debounce core, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bdlp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         result_valid,
	input wire logic                         result_stall,
	input wire logic [bdlp_pkg::FIELD_W-1:0] short_events,
	input wire logic [bdlp_pkg::FIELD_W-1:0] long_events
);

	logic [bdlp_pkg::FIELD_W-1:0] last_short_q;
	logic                         pop;

	assign pop = result_valid && !result_stall;

	// short events of the previous result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_short_q <= '0;
		end else if (pop) begin
			last_short_q <= short_events;
		end
	end

	// a waiting result stays offered
	`BDLP_ASSERT_NXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	// a release and a held press cannot coincide on one button
	`BDLP_ASSERT_IMP(a_no_short_long, clk, arst_n, result_valid, (short_events & long_events) == '0)

	// two releases of one button need a press between them
	`BDLP_ASSERT_IMP(a_no_double_short, clk, arst_n, result_valid, (short_events & last_short_q) == '0)

endmodule

bind button_debounce_long_press_repeat_core bdlp_checker u_bdlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.short_events (short_events),
	.long_events  (long_events)
);

`default_nettype wire

// ===== tb/sv/bdlp_event_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdlp_event_checker
// watches the item, result and configuration ports of the debounce core,
// predicts the short and long events of each poll tick and compares them
// with the results in order of arrival
// ---------------------------------------------------------------------------

module bdlp_event_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic [bdlp_pkg::FIELD_W-1:0]    levels,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [bdlp_pkg::FIELD_W-1:0]    short_events,
	input  logic [bdlp_pkg::FIELD_W-1:0]    long_events,
	input  logic                            cfg_write,
	input  logic [bdlp_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]      cfg_data,
	output int                              errors,
	output int                              pending
);
	import bdlp_pkg::*;

	btn_state_t          btn [NUM_BUTTONS];
	timing_cfg_t         timing;
	logic [FIELD_W-1:0]  long_mask;
	result_t             events_q [$];
	result_t             want;
	int                  err_cnt;

	// one poll tick over all buttons, updating the button state
	function automatic result_t poll_buttons(input logic [FIELD_W-1:0] lv);
		result_t          r;
		logic [ACC_W-1:0] lvw;
		logic [ACC_W-1:0] maskw;
		logic [ACC_W-1:0] sh;
		logic [ACC_W-1:0] lg;
		logic             pressed;
		logic             enabled;
		logic             reached;
		logic [CNT_W-1:0] held;
		lvw   = ACC_W'(lv);
		maskw = ACC_W'(long_mask);
		sh    = '0;
		lg    = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			pressed = ~lvw[i];
			enabled = maskw[i];
			// a raw change restarts the debounce count
			if (pressed != btn[i].sampled) begin
				btn[i].sampled = pressed;
				btn[i].db_cnt  = '0;
			end else if (btn[i].db_cnt < timing.debounce) begin
				btn[i].db_cnt = btn[i].db_cnt + 1'b1;
			end
			if (btn[i].db_cnt >= timing.debounce && btn[i].stable != btn[i].sampled) begin
				held            = btn[i].hold_cnt;
				btn[i].stable   = btn[i].sampled;
				btn[i].hold_cnt = '0;
				btn[i].rep_cnt  = '0;
				if (!btn[i].stable && (!enabled || held < timing.long_press))
					sh[i] = 1'b1;
			end
			if (btn[i].stable && enabled) begin
				reached = 1'b0;
				if (btn[i].hold_cnt < CNT_MAX) begin
					btn[i].hold_cnt = btn[i].hold_cnt + 1'b1;
					reached = (btn[i].hold_cnt == timing.long_press);
				end
				if (reached) begin
					lg[i] = 1'b1;
					btn[i].rep_cnt = '0;
				end else if (btn[i].hold_cnt >= timing.long_press) begin
					if (btn[i].rep_cnt < CNT_MAX)
						btn[i].rep_cnt = btn[i].rep_cnt + 1'b1;
					if (btn[i].rep_cnt >= timing.rep_period) begin
						lg[i] = 1'b1;
						btn[i].rep_cnt = '0;
					end
				end
			end
		end
		r.shorts = sh[FIELD_W-1:0];
		r.longs  = lg[FIELD_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++)
				btn[i] = '0;
			timing.debounce     = RST_DEBOUNCE;
			timing.long_press   = RST_LONG_PRESS;
			timing.rep_period   = RST_REPEAT;
			long_mask           = RST_LONG_MASK;
			events_q.delete();
			err_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DEBOUNCE:   timing.debounce     = cfg_data[DB_W-1:0];
					REG_LONG_PRESS: timing.long_press   = cfg_data[CNT_W-1:0];
					REG_REPEAT:     timing.rep_period   = cfg_data[CNT_W-1:0];
					REG_LONG_MASK:  long_mask           = cfg_data[FIELD_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (events_q.size() == 0) begin
					$error("result with nothing expected: short_events %h, long_events %h",
						short_events, long_events);
					err_cnt++;
				end else begin
					want = events_q.pop_front();
					if (short_events !== want.shorts) begin
						$error("short_events: expected %h, actual %h", want.shorts, short_events);
						err_cnt++;
					end
					if (long_events !== want.longs) begin
						$error("long_events: expected %h, actual %h", want.longs, long_events);
						err_cnt++;
					end
				end
			end
			if (item_valid && !item_stall)
				events_q.push_back(poll_buttons(levels));
			errors  <= err_cnt;
			pending <= events_q.size();
		end
	end

endmodule

// ===== tb/sv/button_debounce_long_press_repeat_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// button_debounce_long_press_repeat_core_tb
// drives poll ticks into the debounce core under several register settings,
// with random idle bursts on both channels; the event checker beside the
// block predicts every result and counts the mismatches
// ---------------------------------------------------------------------------

module button_debounce_long_press_repeat_core_tb;
	import bdlp_pkg::*;

	// margin after every predicted result is checked, before new settings
	localparam int SETTLE     = 2 * (NUM_BUTTONS + 2) + 8;
	// cycles without any transaction before the run is abandoned
	localparam int IDLE_LIMIT = 2000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	logic [FIELD_W-1:0]  levels       = '1;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [FIELD_W-1:0]  short_events;
	logic [FIELD_W-1:0]  long_events;
	logic                cfg_write    = 1'b0;
	logic [CIDX_W-1:0]   cfg_index    = REG_DEBOUNCE;
	logic [CFG_W-1:0]    cfg_data     = '0;
	int                  errors;
	int                  pending;

	// no idling at all once set, for the last part of the run
	bit                  no_idle      = 1'b0;
	int                  stall_left   = 0;
	int                  idle_cycles  = 0;

	// current timing, kept only to shape the press patterns
	int                  cur_db       = RST_DEBOUNCE;
	int                  cur_lp       = RST_LONG_PRESS;
	int                  cur_rep      = RST_REPEAT;

	// per button: wanted level (1 = pressed) and polls left in the current run
	logic [FIELD_W-1:0]  press_tgt    = '0;
	int                  run_left [FIELD_W];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	button_debounce_long_press_repeat_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.levels       (levels),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.short_events (short_events),
		.long_events  (long_events),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bdlp_event_checker event_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.levels       (levels),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.short_events (short_events),
		.long_events  (long_events),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	// result side stalls in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 4);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| cfg_write) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one poll tick transaction, then an optional idle burst
	task automatic send_poll(input logic [FIELD_W-1:0] v);
		item_valid <= 1'b1;
		levels     <= v;
		do
			@(posedge clk);
		while (item_stall);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			levels     <= FIELD_W'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// lower valid and wait until every predicted result has been checked
	task automatic drain_events();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// narrow registers get random junk above their width
	task automatic set_timing(input int db, input int lp, input int rep, input int mask);
		write_reg(REG_DEBOUNCE,   {4'($urandom), 4'(db)});
		write_reg(REG_LONG_PRESS, CFG_W'(lp));
		write_reg(REG_REPEAT,     CFG_W'(rep));
		write_reg(REG_LONG_MASK,  {4'($urandom), 4'(mask)});
		cfg_write <= 1'b0;
		cur_db  = db;
		cur_lp  = lp;
		cur_rep = rep;
	endtask

	// press and release runs per button with occasional bounce; a quarter of
	// the runs are long enough for long presses and repeats
	task automatic run_presses(input int n, input int long_lo, input int long_hi);
		logic [FIELD_W-1:0] v;
		for (int k = 0; k < n; k++) begin
			for (int b = 0; b < FIELD_W; b++) begin
				if (run_left[b] <= 0) begin
					press_tgt[b] = ~press_tgt[b];
					if ($urandom_range(0, 3) == 0)
						run_left[b] = $urandom_range(long_lo, long_hi);
					else
						run_left[b] = $urandom_range(1, 2 * cur_db + 6);
				end
				run_left[b]--;
				v[b] = ~press_tgt[b];
				if ($urandom_range(0, 15) == 0)
					v[b] = ~v[b];
			end
			send_poll(v);
		end
	endtask

	initial begin
		for (int b = 0; b < FIELD_W; b++)
			run_left[b] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: press everything, then release
		repeat (4) send_poll('0);
		repeat (4) send_poll('1);
		drain_events();

		// debounce of zero takes a change at once, repeat of zero fires every poll
		set_timing(0, 3, 0, 4'hF);
		repeat (4) send_poll('0);
		send_poll('1);
		send_poll(4'h5);
		send_poll(4'hA);
		drain_events();

		// start a slow press ...
		set_timing(15, 200, 255, 4'h0);
		repeat (4) send_poll('0);
		drain_events();

		// ... then lower debounce below the count and the threshold to zero mid-hold
		set_timing(2, 0, 1, 4'hF);
		repeat (3) send_poll('0);
		repeat (3) send_poll('1);
		drain_events();

		set_timing(1, 1, 1, 4'hF);
		run_presses(150, 1, 12);
		drain_events();

		set_timing(15, 255, 255, 4'h0);
		run_presses(100, 16, 40);
		drain_events();

		set_timing($urandom_range(0, 15), $urandom_range(1, 40), $urandom_range(0, 20),
			$urandom_range(0, 15));
		run_presses(150, cur_lp, cur_lp + 2 * cur_rep + 10);
		drain_events();

		// holds well past the saturation of the hold count
		set_timing(0, 200, 7, 4'hF);
		run_presses(350, 260, 300);
		drain_events();

		set_timing($urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 15));
		run_presses(150, cur_lp, cur_lp + cur_rep + 10);
		drain_events();

		// last stretch runs flat out on both sides
		no_idle = 1'b1;
		set_timing(4, 0, 0, 4'h5);
		run_presses(100, 4, 30);
		drain_events();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_state_ram.sv
rtl/core/bdlp_btn_upd.sv
rtl/core/bdlp_outq.sv
rtl/core/button_debounce_long_press_repeat_core.sv
rtl/core/bdlp_checker.sv
tb/sv/bdlp_event_checker.sv
tb/sv/button_debounce_long_press_repeat_core_tb.sv
